@@ rtl/core/rsh_pkg.sv @@
// ----------------------------------------------------------------------------
// rsh_pkg
// Shared constants for the replay slot hash unit.
// ----------------------------------------------------------------------------
package rsh_pkg;

    localparam int unsigned MAC_W    = 48;
    localparam int unsigned NONCE_W  = 32;
    localparam int unsigned HASH_W   = 32;
    localparam int unsigned SLOT_W   = 16;
    localparam int unsigned MAC_BYTES = 6;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
    localparam logic [HASH_W-1:0] FIB_MULT  = 32'h9E3779B1;
    localparam int unsigned       FOLD_SHIFT = 16;

    localparam logic [SLOT_W-1:0] SLOT_TOTAL_RST = 16'd64;
    localparam int unsigned       QUEUE_DEPTH_DEF = 4;

endpackage

@@ rtl/core/rsh_hash_front.sv @@
// ----------------------------------------------------------------------------
// rsh_hash_front
// Seven-stage multiply pipeline: FNV-1a over the address bytes, nonce fold,
// Fibonacci multiply and shift-xor. One multiplier per stage.
// ----------------------------------------------------------------------------
module rsh_hash_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [rsh_pkg::MAC_W-1:0]     i_mac_address,
    input  logic [rsh_pkg::NONCE_W-1:0]   i_nonce_value,
    input  logic                          i_q_ready,
    output logic                          o_push,
    output logic [rsh_pkg::HASH_W-1:0]    o_hash
);
    import rsh_pkg::*;

    localparam int unsigned NSTG = MAC_BYTES + 1;

    logic [NSTG-1:0]   r_v;
    logic [HASH_W-1:0] r_h     [NSTG];
    logic [MAC_W-1:0]  r_mac   [NSTG];
    logic [NONCE_W-1:0] r_nonce [NSTG];
    logic              en;
    logic [HASH_W-1:0] hx;

    assign en      = !r_v[NSTG-1] || i_q_ready;
    assign o_stall = !en;
    assign o_push  = r_v[NSTG-1] && i_q_ready;
    assign hx      = r_h[NSTG-1];
    assign o_hash  = hx ^ (hx >> FOLD_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mac[0]   <= i_mac_address;
            r_nonce[0] <= i_nonce_value;
            r_h[0]     <= (FNV_BASIS ^ {24'd0, i_mac_address[MAC_W-1 -: 8]}) * FNV_PRIME;
            for (int s = 1; s < MAC_BYTES; s++) begin
                r_mac[s]   <= r_mac[s-1];
                r_nonce[s] <= r_nonce[s-1];
                r_h[s]     <= (r_h[s-1] ^ {24'd0, r_mac[s-1][8*(MAC_BYTES-1-s) +: 8]})
                              * FNV_PRIME;
            end
            r_mac[NSTG-1]   <= r_mac[NSTG-2];
            r_nonce[NSTG-1] <= r_nonce[NSTG-2];
            r_h[NSTG-1]     <= (r_h[NSTG-2] ^ r_nonce[NSTG-2]) * FIB_MULT;
        end
    end

endmodule

@@ rtl/core/rsh_queue.sv @@
// ----------------------------------------------------------------------------
// rsh_queue
// Small FIFO of mixed hashes between the hash front and the modulo back.
// ----------------------------------------------------------------------------
module rsh_queue #(
    parameter int unsigned DEPTH = rsh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [rsh_pkg::HASH_W-1:0]  i_data,
    output logic                        o_ready,
    input  logic                        i_pop,
    output logic                        o_nonempty,
    output logic [rsh_pkg::HASH_W-1:0]  o_data
);
    import rsh_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [HASH_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wp, r_rp;
    logic [CW-1:0]     r_cnt;
    logic              do_pop;

    assign o_ready    = r_cnt != CW'(DEPTH);
    assign o_nonempty = r_cnt != '0;
    assign o_data     = r_mem[r_rp];
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/core/rsh_mod_back.sv @@
// ----------------------------------------------------------------------------
// rsh_mod_back
// Pipelined restoring remainder, one dividend bit per stage; the last stage
// is the output register.
// ----------------------------------------------------------------------------
module rsh_mod_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [rsh_pkg::SLOT_W-1:0]  i_slot_total,
    input  logic                        i_nonempty,
    input  logic [rsh_pkg::HASH_W-1:0]  i_hash,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [rsh_pkg::SLOT_W-1:0]  o_slot_index
);
    import rsh_pkg::*;

    localparam int unsigned NSTG = HASH_W;

    logic [NSTG-1:0]   r_v;
    logic [SLOT_W-1:0] r_rem [NSTG];
    logic [HASH_W-1:0] r_dvd [NSTG];
    logic              en;

    function automatic logic [SLOT_W-1:0] rem_step(input logic [SLOT_W-1:0] rem,
                                                   input logic bit_in,
                                                   input logic [SLOT_W-1:0] div);
        logic [SLOT_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, div}) begin
            t = t - {1'b0, div};
        end
        return t[SLOT_W-1:0];
    endfunction

    assign en           = !r_v[NSTG-1] || !i_stall;
    assign o_pop        = en;
    assign o_valid      = r_v[NSTG-1];
    assign o_slot_index = (i_slot_total == '0) ? '0 : r_rem[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTG-2:0], i_nonempty};
        end
    end

    // for a nonzero divisor held steady, the remainder stays below it, so 16 bits hold it
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dvd[0] <= {i_hash[HASH_W-2:0], 1'b0};
            r_rem[0] <= rem_step('0, i_hash[HASH_W-1], i_slot_total);
            for (int s = 1; s < NSTG; s++) begin
                r_dvd[s] <= {r_dvd[s-1][HASH_W-2:0], 1'b0};
                r_rem[s] <= rem_step(r_rem[s-1], r_dvd[s-1][HASH_W-1], i_slot_total);
            end
        end
    end

endmodule

@@ rtl/core/replay_slot_hash_unit.sv @@
// ----------------------------------------------------------------------------
// replay_slot_hash_unit
// FNV-1a address/nonce hash with Fibonacci mix, reduced modulo slot count.
// ----------------------------------------------------------------------------
//  channel   valid      stall      payload
//  in        i_valid    o_stall    i_mac_address, i_nonce_value
//  out       o_valid    i_stall    o_slot_index
//  cfg       i_cfg_we   -          i_cfg_wdata (slot_total)
//
//  one beat per cycle sustained while i_stall is low; the multiply
//  pipeline feeds the queue, which registers each hash, then the remainder
//  pipeline (one dividend bit per stage). synchronous active-low reset
//  sets slot_total to 64 and empties all stages. front and back stall
//  independently; the queue absorbs the difference.
// ----------------------------------------------------------------------------
module replay_slot_hash_unit #(
    parameter int unsigned QUEUE_DEPTH = rsh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rsh_pkg::SLOT_W-1:0]    i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [rsh_pkg::MAC_W-1:0]     i_mac_address,
    input  logic [rsh_pkg::NONCE_W-1:0]   i_nonce_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rsh_pkg::SLOT_W-1:0]    o_slot_index
);
    import rsh_pkg::*;

    logic [SLOT_W-1:0] r_slot_total;
    logic              q_ready, q_push, q_pop, q_nonempty;
    logic [HASH_W-1:0] q_wdata, q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_total <= SLOT_TOTAL_RST;
        end else if (i_cfg_we) begin
            r_slot_total <= i_cfg_wdata;
        end
    end

    rsh_hash_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mac_address(i_mac_address),
        .i_nonce_value(i_nonce_value),
        .i_q_ready    (q_ready),
        .o_push       (q_push),
        .o_hash       (q_wdata)
    );

    rsh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_data    (q_wdata),
        .o_ready   (q_ready),
        .i_pop     (q_pop),
        .o_nonempty(q_nonempty),
        .o_data    (q_rdata)
    );

    rsh_mod_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_slot_total(r_slot_total),
        .i_nonempty  (q_nonempty),
        .i_hash      (q_rdata),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_slot_index(o_slot_index)
    );

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_slot_total != '0 |-> o_slot_index < r_slot_total)
        else $error("slot index beyond slot count");

    a_zero_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_slot_total == '0 |-> o_slot_index == '0)
        else $error("nonzero slot with zero slot count");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_ready |-> !q_push)
        else $error("queue written while full");

endmodule
